// File: rtl/dsed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsed_pkg
// shared widths, defaults and types of the dog scale-space extremum detector
// ----------------------------------------------------------------------------
package dsed_pkg;

    localparam int PIX_W         = 8;
    localparam int TRIPLE_W      = 3 * PIX_W;
    localparam int LINE_W        = 2 * TRIPLE_W;
    localparam int COORD_W       = 11;
    localparam int CFG_W         = 12;
    localparam int MIN_WIDTH     = 3;
    localparam int WIDTH_RESET   = 640;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int N_LANES       = 9;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 24;

    // lane verdict for one window position
    typedef struct packed {
        logic max_ok;
        logic min_ok;
    } lane_flags_t;

    typedef logic [TRIPLE_W-1:0] triple_t;

endpackage
`default_nettype wire

// File: rtl/dsed_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsed_line_store
// two-row line store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dsed_line_store #(
    parameter int DEPTH = dsed_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic      [dsed_pkg::LINE_W-1:0] rd_data,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  wire logic [dsed_pkg::LINE_W-1:0] wr_data
);

    logic [dsed_pkg::LINE_W-1:0] mem [DEPTH];
    logic [dsed_pkg::LINE_W-1:0] rd_data_reg;
    logic [dsed_pkg::LINE_W-1:0] fwd_data_reg;
    logic                        fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read and write to the same column in one cycle: hand the new word over
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/dsed_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsed_lane
// compares one window position of all three planes against the centre
// ----------------------------------------------------------------------------
module dsed_lane (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire dsed_pkg::triple_t          triple,
    input  wire logic [dsed_pkg::PIX_W-1:0] centre,
    output dsed_pkg::lane_flags_t           flags
);

    logic [dsed_pkg::PIX_W-1:0] lo;
    logic [dsed_pkg::PIX_W-1:0] mi;
    logic [dsed_pkg::PIX_W-1:0] up;
    dsed_pkg::lane_flags_t      flags_next;
    dsed_pkg::lane_flags_t      flags_reg;

    assign lo = triple[dsed_pkg::PIX_W-1:0];
    assign mi = triple[2*dsed_pkg::PIX_W-1:dsed_pkg::PIX_W];
    assign up = triple[3*dsed_pkg::PIX_W-1:2*dsed_pkg::PIX_W];

    // outer planes strict, middle plane may tie
    always_comb begin
        flags_next.max_ok = (lo < centre) && (mi <= centre) && (up < centre);
        flags_next.min_ok = (lo > centre) && (mi >= centre) && (up > centre);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule
`default_nettype wire

// File: rtl/dsed_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsed_merge
// combines the lane verdicts and holds the result register
// ----------------------------------------------------------------------------
module dsed_merge (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        en,
    input  wire logic                                        in_valid,
    input  wire logic                                        in_judge,
    input  wire logic [dsed_pkg::COORD_W-1:0]                in_row,
    input  wire logic [dsed_pkg::COORD_W-1:0]                in_col,
    input  wire dsed_pkg::lane_flags_t [dsed_pkg::N_LANES-1:0] lane_flags,
    output logic                                             out_valid,
    output logic                                             out_centre_valid,
    output logic                                             out_is_extremum,
    output logic      [dsed_pkg::COORD_W-1:0]                out_row,
    output logic      [dsed_pkg::COORD_W-1:0]                out_col
);

    logic                          all_max;
    logic                          all_min;
    logic                          valid_reg;
    logic                          centre_valid_reg;
    logic                          is_extremum_reg;
    logic [dsed_pkg::COORD_W-1:0]  row_reg;
    logic [dsed_pkg::COORD_W-1:0]  col_reg;

    always_comb begin
        all_max = 1'b1;
        all_min = 1'b1;
        for (int i = 0; i < dsed_pkg::N_LANES; i++) begin
            all_max = all_max & lane_flags[i].max_ok;
            all_min = all_min & lane_flags[i].min_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            centre_valid_reg <= in_judge;
            is_extremum_reg  <= in_judge && (all_max || all_min);
            row_reg          <= in_judge ? in_row : '0;
            col_reg          <= in_judge ? in_col : '0;
        end
    end

    assign out_valid        = valid_reg;
    assign out_centre_valid = centre_valid_reg;
    assign out_is_extremum  = is_extremum_reg;
    assign out_row          = row_reg;
    assign out_col          = col_reg;

endmodule
`default_nettype wire

// File: rtl/dog_scale_space_extremum_detect_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dog_scale_space_extremum_detect_top
// 3x3x3 extremum detector over three difference-of-gaussian planes
// ----------------------------------------------------------------------------
//  channel   direction  ports                     contents
//  s_        in         s_tvalid/s_tready/tdata   tdata: lower, middle, upper
//                       s_tuser                   tuser: frame_start
//  m_        out        m_tvalid/m_tready/tdata   tdata: is_extremum, row, col
//                       m_tuser                   tuser: centre_valid
//  cfg_      in         cfg_valid/cfg_ready/data  line_width, always ready
//
//  one transfer in per clock unless stalled, one result out per transfer, through
//  counters and line store read, window, lane compare and merge register
//  the line store has one read and one write port per cycle; a same-column
//  read during write is forwarded inside the store
//  the whole pipeline stalls together while a result waits with m_tready low
//  aresetn (synchronous) clears the counters, window, valids; width to 640
//  the line store holds no reset and needs no clearing pass
// ----------------------------------------------------------------------------
module dog_scale_space_extremum_detect_top #(
    parameter int MAX_WIDTH  = dsed_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dsed_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input pixel stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [dsed_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] dog_lower, [15:8] dog_middle,
                                                          // [23:16] dog_upper
    input  wire logic                           s_tuser,  // [0] frame_start
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [dsed_pkg::M_TDATA_W-1:0] m_tdata,  // [0] is_extremum, [11:1] centre_row,
                                                          // [22:12] centre_col, [23] zero
    output logic                                m_tuser,  // [0] centre_valid
    // line_width register
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dsed_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = (AW + 1 > dsed_pkg::CFG_W) ? AW + 1 : dsed_pkg::CFG_W;
    localparam int RXW = (RW > dsed_pkg::COORD_W) ? RW : dsed_pkg::COORD_W;
    localparam int CXW = (AW > dsed_pkg::COORD_W) ? AW : dsed_pkg::COORD_W;
    localparam int RESET_WIDTH = (dsed_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                 MAX_WIDTH : dsed_pkg::WIDTH_RESET;

    // handshakes
    logic adv;
    logic s_accept;

    // effective line width, clamped on write
    logic [WW-1:0] width_reg;
    logic [WW-1:0] cfg_ext;
    logic [WW-1:0] width_next;

    // position counters
    logic [AW-1:0] col_cnt_reg;
    logic [AW-1:0] col_cnt_next;
    logic [RW-1:0] row_cnt_reg;
    logic [RW-1:0] row_cnt_next;
    logic [AW-1:0] col_start;
    logic [RW-1:0] row_start;
    logic [AW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [WW-1:0] col_inc;
    logic          cur_judge;

    // stage a: after accept, line store read in flight
    logic                        a_valid_reg;
    dsed_pkg::triple_t           a_cur_reg;
    logic [AW-1:0]               a_col_reg;
    logic [RW-1:0]               a_row_reg;
    logic                        a_judge_reg;
    logic [dsed_pkg::LINE_W-1:0] ls_rd_data;
    dsed_pkg::triple_t           above;
    dsed_pkg::triple_t           above2;
    logic                        ls_wr_en;

    // window, [row][col], row 2 and col 2 newest
    dsed_pkg::triple_t win_reg [3][3];

    // stage b: window holds this item's neighbourhood
    logic          b_valid_reg;
    logic          b_judge_reg;
    logic [RW-1:0] b_row_reg;
    logic [AW-1:0] b_col_reg;
    logic [RXW-1:0] b_row_m1;
    logic [CXW-1:0] b_col_m1;

    // stage c: lane verdicts registered
    logic                               c_valid_reg;
    logic                               c_judge_reg;
    logic [dsed_pkg::COORD_W-1:0]       c_row_reg;
    logic [dsed_pkg::COORD_W-1:0]       c_col_reg;
    dsed_pkg::lane_flags_t [dsed_pkg::N_LANES-1:0] lane_flags;

    // result fields
    logic                         out_centre_valid;
    logic                         out_is_extremum;
    logic [dsed_pkg::COORD_W-1:0] out_row;
    logic [dsed_pkg::COORD_W-1:0] out_col;

    function automatic logic [RW-1:0] row_step(input logic [RW-1:0] r);
        return (r < RW'(MAX_HEIGHT - 1)) ? r + RW'(1) : r;
    endfunction

    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- config
    always_comb begin
        cfg_ext = WW'(cfg_data);
        if (cfg_ext < WW'(dsed_pkg::MIN_WIDTH)) begin
            width_next = WW'(dsed_pkg::MIN_WIDTH);
        end else if (cfg_ext > WW'(MAX_WIDTH)) begin
            width_next = WW'(MAX_WIDTH);
        end else begin
            width_next = cfg_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WW'(RESET_WIDTH);
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= width_next;
        end
    end

    // ------------------------------------------------------------- counters
    always_comb begin
        col_start = s_tuser ? '0 : col_cnt_reg;
        row_start = s_tuser ? '0 : row_cnt_reg;
        // a count left beyond a narrowed width wraps first
        if (WW'(col_start) >= width_reg) begin
            cur_col = '0;
            cur_row = row_step(row_start);
        end else begin
            cur_col = col_start;
            cur_row = row_start;
        end
        col_inc = WW'(cur_col) + WW'(1);
        if (col_inc >= width_reg) begin
            col_cnt_next = '0;
            row_cnt_next = row_step(cur_row);
        end else begin
            col_cnt_next = col_inc[AW-1:0];
            row_cnt_next = cur_row;
        end
        cur_judge = (cur_row >= RW'(2)) && (cur_col >= AW'(2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (s_accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // --------------------------------------------------------------- stage a
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_cur_reg   <= s_tdata[dsed_pkg::TRIPLE_W-1:0];
            a_col_reg   <= cur_col;
            a_row_reg   <= cur_row;
            a_judge_reg <= cur_judge;
        end
    end

    assign above    = ls_rd_data[dsed_pkg::TRIPLE_W-1:0];
    assign above2   = ls_rd_data[dsed_pkg::LINE_W-1:dsed_pkg::TRIPLE_W];
    assign ls_wr_en = adv && a_valid_reg;

    dsed_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (cur_col),
        .rd_data (ls_rd_data),
        .wr_en   (ls_wr_en),
        .wr_addr (a_col_reg),
        .wr_data ({above, a_cur_reg})
    );

    // ---------------------------------------------------------------- window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (ls_wr_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= above2;
            win_reg[1][2] <= above;
            win_reg[2][2] <= a_cur_reg;
        end
    end

    // --------------------------------------------------------------- stage b
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ls_wr_en) begin
            b_judge_reg <= a_judge_reg;
            b_row_reg   <= a_row_reg;
            b_col_reg   <= a_col_reg;
        end
    end

    // centre sits one row and one column back
    assign b_row_m1 = RXW'(b_row_reg) - RXW'(1);
    assign b_col_m1 = CXW'(b_col_reg) - CXW'(1);

    // one lane per window position
    for (genvar gi = 0; gi < dsed_pkg::N_LANES; gi++) begin : g_lane
        dsed_lane u_lane (
            .aclk   (aclk),
            .en     (adv),
            .triple (win_reg[gi / 3][gi % 3]),
            .centre (win_reg[1][1][2*dsed_pkg::PIX_W-1:dsed_pkg::PIX_W]),
            .flags  (lane_flags[gi])
        );
    end

    // --------------------------------------------------------------- stage c
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && b_valid_reg) begin
            c_judge_reg <= b_judge_reg;
            c_row_reg   <= b_row_m1[dsed_pkg::COORD_W-1:0];
            c_col_reg   <= b_col_m1[dsed_pkg::COORD_W-1:0];
        end
    end

    dsed_merge u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (adv),
        .in_valid         (c_valid_reg),
        .in_judge         (c_judge_reg),
        .in_row           (c_row_reg),
        .in_col           (c_col_reg),
        .lane_flags       (lane_flags),
        .out_valid        (m_tvalid),
        .out_centre_valid (out_centre_valid),
        .out_is_extremum  (out_is_extremum),
        .out_row          (out_row),
        .out_col          (out_col)
    );

    assign m_tuser = out_centre_valid;
    assign m_tdata = {1'b0, out_col, out_row, out_is_extremum};

`ifndef NO_ASSERTIONS
    // an extremum is only ever reported for a judged centre
    a_ext_needs_centre: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tdata[0])
        else $error("extremum flagged without a judged centre");

    // the column count always addresses a line store entry
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_cnt_reg) < MAX_WIDTH)
        else $error("column count beyond line store");

    // the row count saturates at the last row
    a_row_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(row_cnt_reg) <= MAX_HEIGHT - 1)
        else $error("row count beyond last row");

    // a frame start places its pixel at row 0, column 0
    a_frame_start_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser |=> a_valid_reg && a_row_reg == '0 && a_col_reg == '0)
        else $error("frame start did not restart the counters");
`endif

endmodule
`default_nettype wire

// File: sim/dog_scale_space_extremum_detect_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dog_scale_space_extremum_detect_top_tb
// self-checking bench for the 3x3x3 dog scale-space extremum detector
// ----------------------------------------------------------------------------
//  pixels come from a queue that the stimulus process fills frame by frame.
//  each accepted pixel is run through a local model of the line stores and
//  window, and the verdict it gives is queued. every result transfer is
//  checked field by field against the oldest queued verdict. line_width is
//  only rewritten once the pipeline has drained. both stream sides idle at
//  random, in three stretches of different weight
// ----------------------------------------------------------------------------
module dog_scale_space_extremum_detect_top_tb;

    localparam int MAX_W = dsed_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H = dsed_pkg::MAX_HEIGHT_DEF;

    // one pixel transfer, as the bench sees it
    typedef struct packed {
        logic [dsed_pkg::PIX_W-1:0] lower;
        logic [dsed_pkg::PIX_W-1:0] middle;
        logic [dsed_pkg::PIX_W-1:0] upper;
        logic                       frame_start;
    } pixel_t;

    // one result transfer
    typedef struct packed {
        logic                         centre_valid;
        logic                         is_extremum;
        logic [dsed_pkg::COORD_W-1:0] row;
        logic [dsed_pkg::COORD_W-1:0] col;
    } verdict_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [dsed_pkg::S_TDATA_W-1:0] s_tdata   = '0;   // [7:0] lower, [15:8] middle,
                                                      // [23:16] upper
    logic                           s_tuser   = 1'b0; // [0] frame_start
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [dsed_pkg::M_TDATA_W-1:0] m_tdata;          // [0] is_extremum, [11:1] row,
                                                      // [22:12] col
    logic                           m_tuser;          // [0] centre_valid
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dsed_pkg::CFG_W-1:0]     cfg_data  = '0;

    dog_scale_space_extremum_detect_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // local model of the detector: line stores, window, counters, width
    // ------------------------------------------------------------------------
    logic [dsed_pkg::LINE_W-1:0] line_mem [MAX_W] = '{default: '0};
    dsed_pkg::triple_t           win [3][3]       = '{default: '0};
    int unsigned                 col_pos          = 0;
    int unsigned                 row_pos          = 0;
    logic [dsed_pkg::CFG_W-1:0]  width_reg        =
        dsed_pkg::CFG_W'(dsed_pkg::WIDTH_RESET);

    pixel_t      pixel_q [$];   // pixels waiting to be sent
    verdict_t    verdict_q [$]; // verdicts waiting for their result transfer
    bit          s_took       = 1'b0;
    int unsigned fail_count   = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned rand_items   = 0;
    bit          held_once    = 1'b0;

    // move to column 0 of the next row, row count saturating at the last row
    function automatic void wrap_row();
        col_pos = 0;
        if (row_pos < MAX_H - 1) row_pos++;
    endfunction

    function automatic verdict_t predict_verdict(pixel_t px);
        int unsigned                 w;
        int unsigned                 c;
        logic [dsed_pkg::LINE_W-1:0] held;
        dsed_pkg::triple_t           cur;
        logic [dsed_pkg::PIX_W-1:0]  ctr;
        logic [dsed_pkg::PIX_W-1:0]  lo;
        logic [dsed_pkg::PIX_W-1:0]  mi;
        logic [dsed_pkg::PIX_W-1:0]  up;
        logic                        is_max;
        logic                        is_min;
        verdict_t                    v;
        // out-of-range widths clamp to the supported span
        w = width_reg;
        if (w < dsed_pkg::MIN_WIDTH) w = dsed_pkg::MIN_WIDTH;
        if (w > MAX_W) w = MAX_W;
        if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        // a width shrunk under the current column wraps before this pixel
        if (col_pos >= w) wrap_row();
        c    = col_pos;
        cur  = {px.upper, px.middle, px.lower};
        held = line_mem[c];
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2]   = held[dsed_pkg::LINE_W-1:dsed_pkg::TRIPLE_W];
        win[1][2]   = held[dsed_pkg::TRIPLE_W-1:0];
        win[2][2]   = cur;
        line_mem[c] = {held[dsed_pkg::TRIPLE_W-1:0], cur};
        v = '0;
        if (row_pos >= 2 && c >= 2) begin
            ctr    = win[1][1][2*dsed_pkg::PIX_W-1:dsed_pkg::PIX_W];
            is_max = 1'b1;
            is_min = 1'b1;
            // outer planes strict, middle plane allows ties (centre ties itself)
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    lo = win[r][k][dsed_pkg::PIX_W-1:0];
                    mi = win[r][k][2*dsed_pkg::PIX_W-1:dsed_pkg::PIX_W];
                    up = win[r][k][3*dsed_pkg::PIX_W-1:2*dsed_pkg::PIX_W];
                    if (lo >= ctr || mi > ctr || up >= ctr) is_max = 1'b0;
                    if (lo <= ctr || mi < ctr || up <= ctr) is_min = 1'b0;
                end
            end
            v.centre_valid = 1'b1;
            v.is_extremum  = is_max | is_min;
            v.row          = dsed_pkg::COORD_W'(row_pos - 1);
            v.col          = dsed_pkg::COORD_W'(c - 1);
        end
        col_pos = c + 1;
        if (col_pos >= w) wrap_row();
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // monitor: register writes, pixel transfers and result transfers are all
    // taken at the rising edge, before the block's own updates land
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        pixel_t   px;
        verdict_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) width_reg = cfg_data;
            s_took = s_tvalid && s_tready;
            if (s_took) begin
                px.lower       = s_tdata[dsed_pkg::PIX_W-1:0];
                px.middle      = s_tdata[2*dsed_pkg::PIX_W-1:dsed_pkg::PIX_W];
                px.upper       = s_tdata[3*dsed_pkg::PIX_W-1:2*dsed_pkg::PIX_W];
                px.frame_start = s_tuser;
                verdict_q = {verdict_q, predict_verdict(px)};
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("result transfer with nothing pending: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tuser !== want.centre_valid) begin
                        $error("centre_valid: expected %0d, actual %0d",
                               want.centre_valid, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[0] !== want.is_extremum) begin
                        $error("is_extremum: expected %0d, actual %0d",
                               want.is_extremum, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[dsed_pkg::COORD_W:1] !== want.row) begin
                        $error("centre_row: expected %0d, actual %0d",
                               want.row, m_tdata[dsed_pkg::COORD_W:1]);
                        fail_count++;
                    end
                    if (m_tdata[2*dsed_pkg::COORD_W:dsed_pkg::COORD_W+1] !== want.col) begin
                        $error("centre_col: expected %0d, actual %0d",
                               want.col, m_tdata[2*dsed_pkg::COORD_W:dsed_pkg::COORD_W+1]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver: a new pixel is offered once the last one has gone, unless the
    // sender idles this cycle; the receiver stalls at its own rate
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        pixel_t nxt;
        if (aresetn && (!s_tvalid || s_took)) begin
            if (pixel_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.upper, nxt.middle, nxt.lower};
                s_tuser  <= nxt.frame_start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // flat planes with the odd spike or dip give a fair share of extrema;
    // uniform pixels exercise every data bit
    function automatic pixel_t make_pixel(bit uniform, bit fs);
        pixel_t px;
        px.frame_start = fs;
        if (uniform) begin
            px.lower  = dsed_pkg::PIX_W'($urandom);
            px.middle = dsed_pkg::PIX_W'($urandom);
            px.upper  = dsed_pkg::PIX_W'($urandom);
        end else begin
            px.lower  = dsed_pkg::PIX_W'($urandom_range(96, 110));
            px.middle = dsed_pkg::PIX_W'($urandom_range(100, 106));
            px.upper  = dsed_pkg::PIX_W'($urandom_range(96, 110));
            case ($urandom_range(0, 9))
                0: px.middle = dsed_pkg::PIX_W'($urandom_range(240, 255));
                1: px.middle = dsed_pkg::PIX_W'($urandom_range(0, 15));
                default: ;
            endcase
        end
        return px;
    endfunction

    task automatic queue_frame(int unsigned n, bit flagged, bit noisy, bit uniform);
        bit fs;
        for (int unsigned k = 0; k < n; k++) begin
            fs = (flagged && k == 0) || (noisy && $urandom_range(0, 63) == 0);
            pixel_q = {pixel_q, make_pixel(uniform, fs)};
        end
    endtask

    // hold the sender back until every verdict has come out, then let the
    // pipeline settle
    task automatic wait_drained();
        do @(posedge aclk); while (pixel_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_line_width(logic [dsed_pkg::CFG_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // a width, then frames of random content; most are whole frames, a few
    // are cut short, run on without a start flag or carry stray start flags
    task automatic random_phase();
        int unsigned w;
        int unsigned goal;
        int unsigned got;
        int unsigned n;
        int unsigned roll;
        bit          first;
        roll = $urandom_range(0, 19);
        if (roll < 2) w = $urandom_range(0, 2);
        else if (roll < 16) w = $urandom_range(3, 10);
        else w = $urandom_range(11, 40);
        write_line_width(dsed_pkg::CFG_W'(w));
        if (w < dsed_pkg::MIN_WIDTH) w = dsed_pkg::MIN_WIDTH;
        goal  = $urandom_range(120, 260);
        got   = 0;
        first = 1'b1;
        while (got < goal) begin
            roll = $urandom_range(0, 9);
            n    = w * $urandom_range(3, 6);
            if (roll == 0) n = $urandom_range(1, n);
            // the first frame after a width change always restarts the counts
            queue_frame(n, first || roll != 1, roll == 2, $urandom_range(0, 3) == 0);
            got  += n;
            first = 1'b0;
            if (!held_once || $urandom_range(0, 7) == 0) begin
                wait_drained();
                held_once = 1'b1;
            end
        end
        rand_items += got;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        pixel_t px;
        // sender mostly busy, receiver mostly stalled
        src_idle_pct = 6;
        snk_idle_pct = 82;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset width: past the column wrap at 640
        queue_frame(700, 1'b1, 1'b0, 1'b1);

        // directed 7x4 frame: a clear maximum, a clear minimum, a plateau
        // maximum that ties its middle-plane neighbours, and field extremes
        write_line_width(dsed_pkg::CFG_W'(7));
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 7; c++) begin
                px.lower       = 8'h10;
                px.middle      = 8'h80;
                px.upper       = 8'h10;
                px.frame_start = (r == 0 && c == 0);
                if (r == 1 && c == 1) px.middle = 8'hff;
                if (r == 1 && c == 5) px.middle = 8'h00;
                if (r == 3 && c == 6) px.lower = 8'hff;
                if (r == 3 && c == 0) begin
                    px.lower = 8'h00;
                    px.upper = 8'h00;
                end
                pixel_q = {pixel_q, px};
            end
        end

        // width changed mid-frame: shrink under the current column so it
        // wraps, then widen again over columns already filled this frame
        write_line_width(dsed_pkg::CFG_W'(6));
        queue_frame(17, 1'b1, 1'b0, 1'b0);
        write_line_width(dsed_pkg::CFG_W'(4));
        queue_frame(4, 1'b0, 1'b0, 1'b0);
        write_line_width(dsed_pkg::CFG_W'(6));
        queue_frame(6, 1'b0, 1'b0, 1'b0);

        while (rand_items < 230) random_phase();

        // now the sender idles most, the receiver rarely
        src_idle_pct = 82;
        snk_idle_pct = 6;

        // widest line; the mid-frame rewrite to an over-range value must
        // clamp to the same width, so the row carries on unbroken
        write_line_width(dsed_pkg::CFG_W'(MAX_W));
        queue_frame(150, 1'b1, 1'b0, 1'b0);
        write_line_width(dsed_pkg::CFG_W'(4095));
        queue_frame(100, 1'b0, 1'b0, 1'b0);

        while (rand_items < 600) random_phase();

        // no idling from here on
        src_idle_pct = 0;
        snk_idle_pct = 0;

        // under-range width acts as the narrowest line
        write_line_width(dsed_pkg::CFG_W'(2));
        queue_frame(45, 1'b1, 1'b0, 1'b0);

        while (rand_items < 950) random_phase();

        wait_drained();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
